// File: rtl/ntfs_runlist_decoder_core_macros.svh
// assertion helpers shared by the rtl files
// each macro expects clk and rst_n in scope
`ifndef NTFS_RUNLIST_DECODER_CORE_MACROS_SVH
`define NTFS_RUNLIST_DECODER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define NTFS_RL_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ntfs runlist decoder: same-cycle check failed");

// next-cycle implication
`define NTFS_RL_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ntfs runlist decoder: next-cycle check failed");

`else

`define NTFS_RL_ASSERT_IMPL(name, ante, cons)
`define NTFS_RL_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// File: rtl/ntfs_rl_pkg.sv
package ntfs_rl_pkg;

  // parser phases
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_LENGTH = 2'd1;
  localparam logic [1:0] PH_OFFSET = 2'd2;
  localparam logic [1:0] PH_ENDED  = 2'd3;

  // job kinds passed from parser to executor
  localparam logic [1:0] JOB_RUN = 2'd0;
  localparam logic [1:0] JOB_END = 2'd1;
  localparam logic [1:0] JOB_BAD = 2'd2;

  localparam logic [3:0] MAX_FIELD_BYTES = 4'd8;
  localparam logic [7:0] CPR_RESET       = 8'd1;
  localparam int         QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic [1:0]  kind;
    logic        clr_prev;
    logic [3:0]  osize;
    logic [63:0] len;
    logic [63:0] off;
  } job_t;

  // two's complement extension of an offset field of osize bytes
  function automatic logic [63:0] sext_offset(input logic [63:0] off, input logic [3:0] osize);
    logic [63:0] r;
    begin
      unique case (osize)
        4'd1:    r = {{56{off[7]}},  off[7:0]};
        4'd2:    r = {{48{off[15]}}, off[15:0]};
        4'd3:    r = {{40{off[23]}}, off[23:0]};
        4'd4:    r = {{32{off[31]}}, off[31:0]};
        4'd5:    r = {{24{off[39]}}, off[39:0]};
        4'd6:    r = {{16{off[47]}}, off[47:0]};
        4'd7:    r = {{8{off[55]}},  off[55:0]};
        default: r = off;
      endcase
      return r;
    end
  endfunction

endpackage

// File: rtl/ntfs_runlist_decoder_core.sv
// ntfs data-run list decoder
// input channel: one byte of the run list per transaction (in_run_byte),
//   in_list_start marks the first byte of a new list and clears the
//   running start cluster
// output channel: one transaction per completed run with start, end and
//   record count, or one with out_list_done set for a terminator or, with
//   out_bad_header also set, for an illegal header
// cfg port: cfg_we writes cfg_wdata into clusters_per_record (0 acts as 1)
// throughput: bytes are taken one per cycle by the parser while the job
//   queue has room; the executor works on one job at a time: it pops it,
//   adds the offset, runs the byte-per-cycle divider and loads the result;
//   terminator and error jobs skip the offset add and the divider
// reset: synchronous, active low; parser waits for a header, start cluster
//   is zero, clusters_per_record is 1, queue and output register empty
// stall: a result waits in the output register while out_ready is low; the
//   executor can still pop and work on the next job, and the parser keeps
//   taking bytes until the queue fills, then drops in_ready
module ntfs_runlist_decoder_core #(
  parameter int QUEUE_DEPTH = ntfs_rl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_run_byte,
  input  logic        in_list_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [62:0] out_start_cluster,
  output logic [62:0] out_end_cluster,
  output logic [62:0] out_record_count,
  output logic        out_list_done,
  output logic        out_bad_header,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  // clusters per file record, divisor for the record count
  logic [7:0] cpr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpr_r <= ntfs_rl_pkg::CPR_RESET;
    end else if (cfg_we) begin
      cpr_r <= cfg_wdata;
    end
  end

  logic              q_full, q_empty;
  logic              push, pop;
  ntfs_rl_pkg::job_t push_job, pop_job;

  // parser stalls only when the queue is full
  assign in_ready = !q_full;

  // header / length / offset parsing, one byte per transaction
  ntfs_rl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_valid && in_ready),
    .run_byte   (in_run_byte),
    .list_start (in_list_start),
    .push       (push),
    .job        (push_job)
  );

  // short job queue decouples parsing from run arithmetic
  ntfs_rl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_job),
    .pop       (pop),
    .pop_data  (pop_job),
    .full      (q_full),
    .empty     (q_empty)
  );

  // start cluster update, end cluster and record count division
  ntfs_rl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cpr       (cpr_r),
    .job_valid (!q_empty),
    .job       (pop_job),
    .job_pop   (pop),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_start (out_start_cluster),
    .out_end   (out_end_cluster),
    .out_count (out_record_count),
    .out_done  (out_list_done),
    .out_bad   (out_bad_header)
  );

endmodule

// File: rtl/ntfs_rl_front.sv
module ntfs_rl_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [7:0]         run_byte,
  input  logic               list_start,
  output logic               push,
  output ntfs_rl_pkg::job_t  job
);

  logic [1:0]  phase_r, phase_nxt;
  logic [3:0]  lsize_r, lsize_nxt;
  logic [3:0]  osize_r, osize_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [63:0] len_r, len_nxt;
  logic [63:0] off_r, off_nxt;
  logic        clr_pend_r, clr_pend_nxt;

  logic [1:0]  eff_phase;
  logic [3:0]  idx_inc;
  logic [63:0] byte_ins;
  logic        clr_now;

  assign eff_phase = list_start ? ntfs_rl_pkg::PH_HEADER : phase_r;
  assign idx_inc   = {1'b0, idx_r} + 4'd1;
  assign byte_ins  = {56'd0, run_byte} << {idx_r, 3'b000};
  assign clr_now   = clr_pend_r | list_start;

  always_comb begin
    phase_nxt    = phase_r;
    lsize_nxt    = lsize_r;
    osize_nxt    = osize_r;
    idx_nxt      = idx_r;
    len_nxt      = len_r;
    off_nxt      = off_r;
    clr_pend_nxt = clr_pend_r;
    push         = 1'b0;
    job.kind     = ntfs_rl_pkg::JOB_RUN;
    job.clr_prev = clr_now;
    job.osize    = osize_r;
    job.len      = len_r;
    job.off      = off_r;
    if (accept) begin
      clr_pend_nxt = clr_now;
      unique case (eff_phase)
        ntfs_rl_pkg::PH_HEADER: begin
          if (run_byte == 8'd0) begin
            push      = 1'b1;
            job.kind  = ntfs_rl_pkg::JOB_END;
            phase_nxt = ntfs_rl_pkg::PH_ENDED;
          end else if (run_byte[3:0] == 4'd0 ||
                       run_byte[3:0] > ntfs_rl_pkg::MAX_FIELD_BYTES ||
                       run_byte[7:4] > ntfs_rl_pkg::MAX_FIELD_BYTES) begin
            push      = 1'b1;
            job.kind  = ntfs_rl_pkg::JOB_BAD;
            phase_nxt = ntfs_rl_pkg::PH_ENDED;
          end else begin
            lsize_nxt = run_byte[3:0];
            osize_nxt = run_byte[7:4];
            idx_nxt   = 3'd0;
            len_nxt   = 64'd0;
            off_nxt   = 64'd0;
            phase_nxt = ntfs_rl_pkg::PH_LENGTH;
          end
        end
        ntfs_rl_pkg::PH_LENGTH: begin
          len_nxt = len_r | byte_ins;
          idx_nxt = idx_inc[2:0];
          if (idx_inc >= lsize_r) begin
            idx_nxt = 3'd0;
            if (osize_r == 4'd0) begin
              push      = 1'b1;
              job.len   = len_r | byte_ins;
              job.off   = 64'd0;
              phase_nxt = ntfs_rl_pkg::PH_HEADER;
            end else begin
              phase_nxt = ntfs_rl_pkg::PH_OFFSET;
            end
          end
        end
        ntfs_rl_pkg::PH_OFFSET: begin
          off_nxt = off_r | byte_ins;
          idx_nxt = idx_inc[2:0];
          if (idx_inc >= osize_r) begin
            idx_nxt   = 3'd0;
            push      = 1'b1;
            job.off   = off_r | byte_ins;
            phase_nxt = ntfs_rl_pkg::PH_HEADER;
          end
        end
        default: begin
          // list ended, bytes dropped until the next list start
        end
      endcase
      if (push) begin
        clr_pend_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= ntfs_rl_pkg::PH_HEADER;
      lsize_r    <= 4'd0;
      osize_r    <= 4'd0;
      idx_r      <= 3'd0;
      len_r      <= 64'd0;
      off_r      <= 64'd0;
      clr_pend_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      lsize_r    <= lsize_nxt;
      osize_r    <= osize_nxt;
      idx_r      <= idx_nxt;
      len_r      <= len_nxt;
      off_r      <= off_nxt;
      clr_pend_r <= clr_pend_nxt;
    end
  end

endmodule

// File: rtl/ntfs_rl_queue.sv
`include "ntfs_runlist_decoder_core_macros.svh"

module ntfs_rl_queue #(
  parameter int DEPTH = ntfs_rl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ntfs_rl_pkg::job_t  push_data,
  input  logic               pop,
  output ntfs_rl_pkg::job_t  pop_data,
  output logic               full,
  output logic               empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ntfs_rl_pkg::job_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  `NTFS_RL_ASSERT_IMPL(a_no_overflow, push, !full)
  `NTFS_RL_ASSERT_IMPL(a_no_underflow, pop, !empty)

endmodule

// File: rtl/ntfs_rl_back.sv
`include "ntfs_runlist_decoder_core_macros.svh"

module ntfs_rl_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         cpr,
  input  logic               job_valid,
  input  ntfs_rl_pkg::job_t  job,
  output logic               job_pop,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [62:0]        out_start,
  output logic [62:0]        out_end,
  output logic [62:0]        out_count,
  output logic               out_done,
  output logic               out_bad
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ADD  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]  state_r;
  logic [1:0]  kind_r;
  logic [3:0]  osize_r;
  logic [63:0] off_r;
  logic [63:0] len_m1_r;
  logic [63:0] prev_r;
  logic [63:0] start_r;
  logic [63:0] end_r;
  logic [63:0] dsh_r;
  logic [63:0] quot_r;
  logic [7:0]  rem_r;
  logic [2:0]  cnt_r;
  logic        out_valid_r;
  logic [62:0] out_start_r, out_end_r, out_count_r;
  logic        out_done_r, out_bad_r;

  logic [7:0]  div_eff;
  logic [63:0] start_nxt;
  logic [7:0]  rem_nxt;
  logic [7:0]  qbyte;
  logic        load;

  assign div_eff   = (cpr == 8'd0) ? 8'd1 : cpr;
  assign start_nxt = prev_r + ntfs_rl_pkg::sext_offset(off_r, osize_r);
  assign job_pop   = (state_r == S_IDLE) && job_valid;
  assign load      = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // one quotient byte per cycle, eight restoring steps on the 8-bit remainder
  always_comb begin
    logic [8:0] t;
    logic [7:0] r;
    r = rem_r;
    qbyte = 8'd0;
    for (int i = 7; i >= 0; i--) begin
      t = {r, dsh_r[56 + i]};
      if (t >= {1'b0, div_eff}) begin
        t        = t - {1'b0, div_eff};
        qbyte[i] = 1'b1;
      end
      r = t[7:0];
    end
    rem_nxt = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      prev_r      <= 64'd0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            kind_r   <= job.kind;
            osize_r  <= job.osize;
            off_r    <= job.off;
            dsh_r    <= job.len;
            len_m1_r <= job.len - 64'd1;
            if (job.clr_prev) begin
              prev_r <= 64'd0;
            end
            state_r <= (job.kind == ntfs_rl_pkg::JOB_RUN) ? S_ADD : S_DONE;
          end
        end
        S_ADD: begin
          start_r <= start_nxt;
          prev_r  <= start_nxt;
          rem_r   <= 8'd0;
          cnt_r   <= 3'd0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (cnt_r == 3'd0) begin
            end_r <= start_r + len_m1_r;
          end
          rem_r   <= rem_nxt;
          quot_r  <= {quot_r[55:0], qbyte};
          dsh_r   <= {dsh_r[55:0], 8'd0};
          cnt_r   <= cnt_r + 3'd1;
          if (cnt_r == 3'd7) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (kind_r == ntfs_rl_pkg::JOB_RUN) begin
        out_start_r <= start_r[62:0];
        out_end_r   <= end_r[62:0];
        out_count_r <= quot_r[62:0];
        out_done_r  <= 1'b0;
        out_bad_r   <= 1'b0;
      end else begin
        out_start_r <= 63'd0;
        out_end_r   <= 63'd0;
        out_count_r <= 63'd0;
        out_done_r  <= 1'b1;
        out_bad_r   <= (kind_r == ntfs_rl_pkg::JOB_BAD);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_start = out_start_r;
  assign out_end   = out_end_r;
  assign out_count = out_count_r;
  assign out_done  = out_done_r;
  assign out_bad   = out_bad_r;

  `NTFS_RL_ASSERT_NEXT(a_pop_leaves_idle, job_pop, state_r != S_IDLE)
  `NTFS_RL_ASSERT_IMPL(a_rem_below_div, state_r == S_DIV, rem_r < div_eff)
  `NTFS_RL_ASSERT_NEXT(a_load_sets_valid, load, out_valid_r)

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  // one decoded extent or list end as seen on the output channel
  typedef struct packed {
    logic [62:0] first_lcn;
    logic [62:0] last_lcn;
    logic [62:0] recs;
    logic        done;
    logic        bad;
  } extent_t;

  // directed stimulus row; typed rows carry their expected extent
  typedef struct {
    logic [7:0] b;
    logic       ls;
    bit         typed;
    extent_t    x;
  } row_t;

  localparam logic [62:0] LCN_ALL_ONES = {63{1'b1}};
  localparam int          SEG_BYTES    = 300;
  localparam int          NUM_SEGS     = 6;
  localparam int          SETTLE_CYC   = 30;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_run_byte = 8'h00;
  logic        in_list_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [62:0] out_start_cluster;
  logic [62:0] out_end_cluster;
  logic [62:0] out_record_count;
  logic        out_list_done;
  logic        out_bad_header;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = 8'h00;

  // shadow of the run-list parser and the divisor register
  logic [1:0]  rl_phase;
  logic [3:0]  len_bytes;
  logic [3:0]  off_bytes;
  logic [3:0]  byte_pos;
  logic [63:0] len_acc;
  logic [63:0] off_acc;
  logic [63:0] prev_lcn;
  logic [7:0]  cpr_reg;

  extent_t extent_q[$];
  row_t    dir_tbl[$];

  // idle percentages per side, changed by the stimulus thread
  int src_idle_pct = 0;
  int sink_idle_pct = 0;

  int errors = 0;
  int bytes_fed = 0;
  int bytes_ignored = 0;
  int useful = 0;
  int n_ext = 0;
  int n_end = 0;
  int n_bad = 0;
  bit long_hold_done = 1'b0;

  ntfs_runlist_decoder_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_run_byte       (in_run_byte),
    .in_list_start     (in_list_start),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_start_cluster (out_start_cluster),
    .out_end_cluster   (out_end_cluster),
    .out_record_count  (out_record_count),
    .out_list_done     (out_list_done),
    .out_bad_header    (out_bad_header),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // close a run: sign-extend the offset, move the start cluster, divide
  task automatic close_run(output extent_t x);
    logic [63:0] off;
    logic [63:0] fld;
    logic [63:0] sgn;
    logic [63:0] first;
    logic [63:0] last;
    logic [63:0] div;
    off = off_acc;
    if (off_bytes > 4'd0 && off_bytes < 4'd8) begin
      fld = (64'd1 << (8 * off_bytes)) - 64'd1;
      sgn = 64'd1 << (8 * off_bytes - 1);
      off = off & fld;
      if ((off & sgn) != 64'd0) off = off | ~fld;
    end
    div = (cpr_reg == 8'd0) ? 64'd1 : {56'd0, cpr_reg};
    first = prev_lcn + off;
    prev_lcn = first;
    last = first + len_acc - 64'd1;
    x = '0;
    x.first_lcn = first[62:0];
    x.last_lcn = last[62:0];
    x.recs = 63'(len_acc / div);
    rl_phase = ntfs_rl_pkg::PH_HEADER;
    byte_pos = 4'd0;
  endtask

  // advance the shadow parser by one byte; got is set when an extent results
  task automatic decode_byte(input logic [7:0] b, input logic ls, output bit got,
                             output extent_t x, output bit ignored);
    logic [3:0] lsz;
    logic [3:0] osz;
    got = 1'b0;
    ignored = 1'b0;
    x = '0;
    lsz = b[3:0];
    osz = b[7:4];
    // list start drops any partial run and the running start cluster
    if (ls) begin
      prev_lcn = '0;
      rl_phase = ntfs_rl_pkg::PH_HEADER;
    end
    case (rl_phase)
      ntfs_rl_pkg::PH_HEADER: begin
        if (b == 8'h00) begin
          rl_phase = ntfs_rl_pkg::PH_ENDED;
          got = 1'b1;
          x.done = 1'b1;
        end else if (lsz == 4'd0 || lsz > ntfs_rl_pkg::MAX_FIELD_BYTES ||
                     osz > ntfs_rl_pkg::MAX_FIELD_BYTES) begin
          rl_phase = ntfs_rl_pkg::PH_ENDED;
          got = 1'b1;
          x.done = 1'b1;
          x.bad = 1'b1;
        end else begin
          len_bytes = lsz;
          off_bytes = osz;
          byte_pos = 4'd0;
          len_acc = '0;
          off_acc = '0;
          rl_phase = ntfs_rl_pkg::PH_LENGTH;
        end
      end
      ntfs_rl_pkg::PH_LENGTH: begin
        len_acc = len_acc | ({56'd0, b} << (8 * byte_pos[2:0]));
        byte_pos = byte_pos + 4'd1;
        if (byte_pos >= len_bytes) begin
          byte_pos = 4'd0;
          // no offset field: run ends on its last length byte
          if (off_bytes == 4'd0) begin
            close_run(x);
            got = 1'b1;
          end else begin
            rl_phase = ntfs_rl_pkg::PH_OFFSET;
          end
        end
      end
      ntfs_rl_pkg::PH_OFFSET: begin
        off_acc = off_acc | ({56'd0, b} << (8 * byte_pos[2:0]));
        byte_pos = byte_pos + 4'd1;
        if (byte_pos >= off_bytes) begin
          close_run(x);
          got = 1'b1;
        end
      end
      default: ignored = 1'b1;
    endcase
  endtask

  // offer one byte, with random idle cycles first, and wait for the transaction;
  // a typed row replaces the shadow parser's extent with its own
  task automatic feed_row(input logic [7:0] b, input logic ls, input bit typed,
                          input extent_t tx);
    bit      got;
    bit      ign;
    extent_t x;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_run_byte <= b;
    in_list_start <= ls;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_byte(b, ls, got, x, ign);
    if (typed) begin
      got = 1'b1;
      x = tx;
    end
    if (got) extent_q.push_back(x);
    bytes_fed++;
    if (ign) bytes_ignored++;
    else useful++;
  endtask

  task automatic feed(input logic [7:0] b, input logic ls);
    feed_row(b, ls, 1'b0, '0);
  endtask

  // stop offering and let the pipeline empty out
  task automatic settle();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (extent_q.size() != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic set_divisor(input logic [7:0] v);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    cpr_reg = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_row(input logic [7:0] b, input logic ls, input bit typed,
                         input logic [62:0] first, input logic [62:0] last,
                         input logic [62:0] recs, input logic done, input logic bad);
    row_t r;
    r.b = b;
    r.ls = ls;
    r.typed = typed;
    r.x = '{first, last, recs, done, bad};
    dir_tbl.push_back(r);
  endtask

  // field byte biased toward the all-zero, all-one and sign-bit patterns
  function automatic logic [7:0] field_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    if (r == 2) return 8'h80;
    return 8'($urandom_range(0, 255));
  endfunction

  // one of the three kinds of illegal header
  function automatic logic [7:0] bad_hdr();
    case ($urandom_range(0, 2))
      0: return {4'($urandom_range(1, 15)), 4'h0};
      1: return {4'($urandom_range(0, 15)), 4'($urandom_range(9, 15))};
      default: return {4'($urandom_range(9, 15)), 4'($urandom_range(1, 8))};
    endcase
  endfunction

  // mostly well-formed lists with random content; some broken lists and noise
  task automatic random_list();
    int kind;
    int nruns;
    int lsz;
    int osz;
    int cut;
    int e;
    int r;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 12))
        feed(8'($urandom_range(0, 255)), ($urandom_range(0, 9) == 0));
      return;
    end
    nruns = $urandom_range(1, 6);
    for (int n = 0; n < nruns; n++) begin
      r = $urandom_range(0, 9);
      lsz = (r < 7) ? $urandom_range(1, 2) : (r < 9) ? $urandom_range(3, 4)
                                                     : $urandom_range(5, 8);
      r = $urandom_range(0, 9);
      osz = (r < 2) ? 0 : (r < 7) ? $urandom_range(1, 3) : $urandom_range(4, 8);
      feed({4'(osz), 4'(lsz)}, n == 0);
      // broken list: abandon the run part way, the next list restarts
      cut = (kind < 18) ? $urandom_range(0, lsz + osz - 1) : lsz + osz;
      for (int i = 0; i < cut; i++) feed(field_byte(), 1'b0);
      if (cut < lsz + osz) return;
    end
    e = $urandom_range(0, 99);
    if (e < 70) feed(8'h00, 1'b0);
    else if (e < 85) feed(bad_hdr(), 1'b0);
    // bytes after the end of a list are dropped by the block
    if (e < 85 && $urandom_range(0, 9) < 3)
      repeat ($urandom_range(1, 3)) feed(8'($urandom_range(1, 255)), 1'b0);
  endtask

  task automatic check_extent();
    extent_t e;
    if (out_list_done && out_bad_header) n_bad++;
    else if (out_list_done) n_end++;
    else n_ext++;
    if (extent_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result: start=%h end=%h recs=%h done=%b bad=%b",
                 out_start_cluster, out_end_cluster, out_record_count,
                 out_list_done, out_bad_header);
      return;
    end
    e = extent_q.pop_front();
    if (out_start_cluster !== e.first_lcn || out_end_cluster !== e.last_lcn ||
        out_record_count !== e.recs || out_list_done !== e.done ||
        out_bad_header !== e.bad) begin
      errors++;
      if (errors <= 10) begin
        $display("mismatch exp: start=%h end=%h recs=%h done=%b bad=%b",
                 e.first_lcn, e.last_lcn, e.recs, e.done, e.bad);
        $display("         got: start=%h end=%h recs=%h done=%b bad=%b",
                 out_start_cluster, out_end_cluster, out_record_count,
                 out_list_done, out_bad_header);
      end
    end
  endtask

  // result side: sample the transaction at the edge, then pick next ready;
  // once, a long hold-off lets the queue fill and back-pressure the input
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) check_extent();
      if (!long_hold_done && bytes_fed >= 400) begin
        hold_left = 300;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  // stimulus: reset, directed table, then random segments per divisor setting
  initial begin
    logic [7:0] divs[NUM_SEGS];
    int         target;
    int         guard;
    divs = '{8'd255, 8'd0, 8'd3, 8'd1, 8'd8, 8'($urandom_range(1, 255))};

    // shadow state after reset
    rl_phase = ntfs_rl_pkg::PH_HEADER;
    len_bytes = '0;
    off_bytes = '0;
    byte_pos = '0;
    len_acc = '0;
    off_acc = '0;
    prev_lcn = '0;
    cpr_reg = ntfs_rl_pkg::CPR_RESET;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // terminator right after reset, then a dropped byte after the end
    add_row(8'h00, 1'b1, 1'b1, 63'd0, 63'd0, 63'd0, 1'b1, 1'b0);
    add_row(8'h55, 1'b0, 1'b0, '0, '0, '0, 1'b0, 1'b0);
    // single length byte, no offset field: starts at cluster zero
    add_row(8'h01, 1'b1, 1'b0, '0, '0, '0, 1'b0, 1'b0);
    add_row(8'h05, 1'b0, 1'b1, 63'd0, 63'd4, 63'd5, 1'b0, 1'b0);
    // zero length run: end wraps to one below the start
    add_row(8'h01, 1'b0, 1'b0, '0, '0, '0, 1'b0, 1'b0);
    add_row(8'h00, 1'b0, 1'b1, 63'd0, LCN_ALL_ONES, 63'd0, 1'b0, 1'b0);
    // widest length, one-byte negative offset
    add_row(8'h18, 1'b0, 1'b0, '0, '0, '0, 1'b0, 1'b0);
    for (int i = 0; i < 8; i++) add_row(8'hFF, 1'b0, 1'b0, '0, '0, '0, 1'b0, 1'b0);
    add_row(8'h80, 1'b0, 1'b0, '0, '0, '0, 1'b0, 1'b0);
    // illegal headers: zero length size, length size above 8, offset size above 8
    add_row(8'h10, 1'b0, 1'b1, 63'd0, 63'd0, 63'd0, 1'b1, 1'b1);
    add_row(8'h09, 1'b1, 1'b1, 63'd0, 63'd0, 63'd0, 1'b1, 1'b1);
    add_row(8'h91, 1'b1, 1'b1, 63'd0, 63'd0, 63'd0, 1'b1, 1'b1);
    add_row(8'hFF, 1'b1, 1'b1, 63'd0, 63'd0, 63'd0, 1'b1, 1'b1);
    // two-byte offset with the sign bit set
    add_row(8'h21, 1'b1, 1'b0, '0, '0, '0, 1'b0, 1'b0);
    add_row(8'h07, 1'b0, 1'b0, '0, '0, '0, 1'b0, 1'b0);
    add_row(8'h00, 1'b0, 1'b0, '0, '0, '0, 1'b0, 1'b0);
    add_row(8'h80, 1'b0, 1'b0, '0, '0, '0, 1'b0, 1'b0);
    add_row(8'h00, 1'b1, 1'b1, 63'd0, 63'd0, 63'd0, 1'b1, 1'b0);

    src_idle_pct = 29;
    sink_idle_pct = 64;
    foreach (dir_tbl[i]) feed_row(dir_tbl[i].b, dir_tbl[i].ls, dir_tbl[i].typed, dir_tbl[i].x);

    // random segments, each under its own divisor; idle mix changes every two
    target = useful;
    for (int s = 0; s < NUM_SEGS; s++) begin
      set_divisor(divs[s]);
      src_idle_pct = (s < 2) ? 29 : (s < 4) ? 64 : 0;
      sink_idle_pct = (s < 2) ? 64 : (s < 4) ? 29 : 0;
      target += SEG_BYTES;
      while (useful < target) random_list();
      feed(8'h00, 1'b1);
    end

    // wait for the last results, bounded
    in_valid <= 1'b0;
    guard = 0;
    while (extent_q.size() != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYC) @(posedge clk);
    if (extent_q.size() != 0) begin
      errors += extent_q.size();
      $display("%0d expected results never arrived", extent_q.size());
    end

    $display("covered %0d bytes (%0d dropped after list end): %0d extents,",
             bytes_fed, bytes_ignored, n_ext);
    $display("%0d list ends, %0d bad headers; six divisor settings incl. 0 and 255,",
             n_end, n_bad);
    $display("three idle mixes, one long output stall; %0d errors", errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
